@@ src/die_pkg.sv @@
// Package for the delta instruction encoder: command codes, item and frame types,
// and the fixed constants of the delta byte format. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package die_pkg;

    typedef enum logic [1:0] {
        CMD_SIZE_HEADER  = 2'd0,
        CMD_COPY_OP      = 2'd1,
        CMD_INSERT_START = 2'd2,
        CMD_INSERT_DATA  = 2'd3
    } cmd_t;

    localparam int FRAME_BYTES = 8;

    localparam logic [7:0]  FLAG_BASE      = 8'h80;
    localparam logic [6:0]  CHUNK_MAX      = 7'd127;
    localparam logic [23:0] COPY_LEN_IMPL  = 24'h010000;

    // One request as captured from the input channel.
    typedef struct packed {
        cmd_t        command;
        logic [31:0] size_value;
        logic [31:0] copy_offset;
        logic [23:0] copy_length;
        logic [23:0] insert_length;
        logic [7:0]  data_byte;
    } item_t;

    // All result bytes of one request, sent one per cycle while m_ready is high.
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [2:0]                  last_idx;
        logic                        bad;
    } frame_t;

endpackage

`default_nettype wire

@@ src/delta_instruction_encoder.sv @@
// Delta instruction encoder top level: input register, insert state, encoder, emitter.
// Depends on die_pkg, die_encode and die_emit.
//
// Usage: each request on the s_ channel is one delta operation (size header,
// copy op, insert start or insert data byte). The m_ channel returns the
// encoded delta bytes one per cycle while m_ready is high; m_last_of_run marks
// the final byte of a request, m_bad_item an out-of-sequence one (one result only).
// A request is captured in the input register, encoded there, and its result
// bytes are then loaded into the result register, which drives m_.
// Throughput: one request per cycle while m_ready is high and each yields at
// most one byte; a request with more bytes holds the result register until its last
// is taken (up to 8 bytes for a copy op), and the input register holds the next one.
// An in-sequence insert start yields no bytes and never waits on the emitter.
// Reset (aresetn low, synchronous) empties both registers and clears the
// pending insert and chunk counts.
// Stall: when m_ready is low the current byte holds; one further request that
// has bytes is still taken into the input register, then s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module delta_instruction_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_size_value,
    input  wire logic [31:0] s_copy_offset,
    input  wire logic [23:0] s_copy_length,
    input  wire logic [23:0] s_insert_length,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run,
    output logic             m_bad_item
);
    import die_pkg::*;

    item_t       item_reg;
    logic        item_valid_reg, item_valid_next;
    logic [23:0] insert_remaining_reg, insert_remaining_next;
    logic [6:0]  chunk_remaining_reg, chunk_remaining_next;

    frame_t      frame;
    logic        has_result;
    logic        state_we;
    logic        can_load;
    logic        advance;
    logic        accept;

    die_encode u_encode (
        .item                  (item_reg),
        .insert_remaining      (insert_remaining_reg),
        .chunk_remaining       (chunk_remaining_reg),
        .frame                 (frame),
        .has_result            (has_result),
        .state_we              (state_we),
        .insert_remaining_next (insert_remaining_next),
        .chunk_remaining_next  (chunk_remaining_next)
    );

    // requests with no result bytes never wait on the emitter
    assign advance = item_valid_reg && (!has_result || can_load);
    assign s_ready = !item_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    die_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && has_result),
        .frame_in      (frame),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_bad_item    (m_bad_item)
    );

    always_comb begin
        item_valid_next = item_valid_reg;
        if (accept) begin
            item_valid_next = 1'b1;
        end else if (advance) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg       <= 1'b0;
            insert_remaining_reg <= '0;
            chunk_remaining_reg  <= '0;
        end else begin
            item_valid_reg <= item_valid_next;
            if (advance && state_we) begin
                insert_remaining_reg <= insert_remaining_next;
                chunk_remaining_reg  <= chunk_remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.command       <= cmd_t'(s_command);
            item_reg.size_value    <= s_size_value;
            item_reg.copy_offset   <= s_copy_offset;
            item_reg.copy_length   <= s_copy_length;
            item_reg.insert_length <= s_insert_length;
            item_reg.data_byte     <= s_data_byte;
        end
    end

endmodule

`default_nettype wire

@@ src/die_encode.sv @@
// Encoder logic: builds the result bytes of one request and the next insert state.
// Depends on die_pkg.
`timescale 1ns / 1ps
`default_nettype none

module die_encode (
    input  var die_pkg::item_t  item,
    input  wire logic [23:0]    insert_remaining,
    input  wire logic [6:0]     chunk_remaining,
    output die_pkg::frame_t     frame,
    output logic                has_result,
    output logic                state_we,
    output logic [23:0]         insert_remaining_next,
    output logic [6:0]          chunk_remaining_next
);
    import die_pkg::*;

    logic [34:0] var_ext;
    logic [2:0]  var_last;
    logic [2:0]  off_nb;
    logic [1:0]  len_nb;
    logic [7:0]  flag;
    logic [2:0]  k;
    logic [2:0]  m;
    logic [6:0]  chunk_cnt;

    always_comb begin
        var_ext = {3'b000, item.size_value};
        if (item.size_value >= 32'h1000_0000)      var_last = 3'd4;
        else if (item.size_value >= 32'h0020_0000) var_last = 3'd3;
        else if (item.size_value >= 32'h0000_4000) var_last = 3'd2;
        else if (item.size_value >= 32'h0000_0080) var_last = 3'd1;
        else                                       var_last = 3'd0;

        if (item.copy_offset >= 32'h0100_0000)      off_nb = 3'd4;
        else if (item.copy_offset >= 32'h0001_0000) off_nb = 3'd3;
        else if (item.copy_offset >= 32'h0000_0100) off_nb = 3'd2;
        else                                        off_nb = 3'd1;

        if (item.copy_length == COPY_LEN_IMPL)      len_nb = 2'd0;
        else if (item.copy_length >= 24'h01_0000)   len_nb = 2'd3;
        else if (item.copy_length >= 24'h00_0100)   len_nb = 2'd2;
        else                                        len_nb = 2'd1;

        flag = FLAG_BASE;
        for (int i = 0; i < 4; i++) begin
            flag[i] = (3'(i) < off_nb);
        end
        for (int i = 0; i < 3; i++) begin
            flag[4 + i] = (2'(i) < len_nb);
        end

        chunk_cnt = (insert_remaining >= 24'(CHUNK_MAX)) ? CHUNK_MAX
                                                         : insert_remaining[6:0];

        frame                 = '0;
        has_result            = 1'b1;
        state_we              = 1'b0;
        insert_remaining_next = insert_remaining;
        chunk_remaining_next  = chunk_remaining;
        k                     = '0;
        m                     = '0;

        unique case (item.command)
            CMD_SIZE_HEADER: begin
                for (int i = 0; i < 5; i++) begin
                    frame.bytes[i] = {(3'(i) < var_last), var_ext[7*i +: 7]};
                end
                frame.last_idx = var_last;
            end
            CMD_COPY_OP: begin
                frame.bytes[0] = flag;
                for (int j = 1; j < FRAME_BYTES; j++) begin
                    k = 3'(j - 1);
                    m = k - off_nb;
                    if (k < off_nb) begin
                        frame.bytes[j] = item.copy_offset[8*k[1:0] +: 8];
                    end else if (m == 3'd0) begin
                        frame.bytes[j] = item.copy_length[7:0];
                    end else if (m == 3'd1) begin
                        frame.bytes[j] = item.copy_length[15:8];
                    end else begin
                        frame.bytes[j] = item.copy_length[23:16];
                    end
                end
                frame.last_idx = off_nb + {1'b0, len_nb};
            end
            CMD_INSERT_START: begin
                if (insert_remaining != '0) begin
                    frame.bad = 1'b1;
                end else begin
                    has_result            = 1'b0;
                    state_we              = 1'b1;
                    insert_remaining_next = item.insert_length;
                    chunk_remaining_next  = '0;
                end
            end
            CMD_INSERT_DATA: begin
                if (insert_remaining == '0) begin
                    frame.bad = 1'b1;
                end else begin
                    state_we              = 1'b1;
                    insert_remaining_next = insert_remaining - 24'd1;
                    if (chunk_remaining == '0) begin
                        // open a new chunk with its count byte
                        frame.bytes[0]       = {1'b0, chunk_cnt};
                        frame.bytes[1]       = item.data_byte;
                        frame.last_idx       = 3'd1;
                        chunk_remaining_next = chunk_cnt - 7'd1;
                    end else begin
                        frame.bytes[0]       = item.data_byte;
                        chunk_remaining_next = chunk_remaining - 7'd1;
                    end
                end
            end
            default: begin
                frame.bad = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/die_emit.sv @@
// Result register: holds one frame of bytes, sent one per cycle while m_ready is high.
// Depends on die_pkg.
`timescale 1ns / 1ps
`default_nettype none

module die_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  var die_pkg::frame_t  frame_in,
    output logic                 can_load,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_last_of_run,
    output logic                 m_bad_item
);
    import die_pkg::*;

    frame_t     frame_reg;
    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       last;

    assign last          = (idx_reg == frame_reg.last_idx);
    assign can_load      = !valid_reg || (last && m_ready);
    assign m_valid       = valid_reg;
    assign m_out_byte    = frame_reg.bytes[idx_reg];
    assign m_last_of_run = last;
    assign m_bad_item    = frame_reg.bad;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (valid_reg && m_ready) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_in;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for delta_instruction_encoder: directed and random delta requests,
// with the byte stream predicted in the bench. Depends on die_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import die_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } enc_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_size_value;
    logic [31:0] s_copy_offset;
    logic [23:0] s_copy_length;
    logic [23:0] s_insert_length;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_bad_item;

    // Predicted stream and the insert counters behind it
    enc_byte_t   owed_bytes[$];
    enc_byte_t   due;
    logic [23:0] ins_left;
    logic [6:0]  chunk_left;
    int          errors;
    int          stall_cycles;
    bit          calm;

    delta_instruction_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_size_value    (s_size_value),
        .s_copy_offset   (s_copy_offset),
        .s_copy_length   (s_copy_length),
        .s_insert_length (s_insert_length),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_run   (m_last_of_run),
        .m_bad_item      (m_bad_item)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic enc_byte_t plain_byte(input logic [7:0] b);
        plain_byte = '{data: b, last: 1'b0, bad: 1'b0};
    endfunction

    // Work out the bytes one accepted request must produce, and advance the insert state.
    task automatic encode_request(input cmd_t cmd, input logic [31:0] sz,
                                  input logic [31:0] off, input logic [23:0] clen,
                                  input logic [23:0] ilen, input logic [7:0] db);
        enc_byte_t   run[$];
        logic [7:0]  flag;
        logic [7:0]  tail[$];
        logic [31:0] v;
        logic [23:0] l;
        logic [6:0]  cnt;
        int          i;
        case (cmd)
            CMD_SIZE_HEADER: begin
                v = sz;
                while (v > 32'h7f) begin
                    run.push_back(plain_byte({1'b1, v[6:0]}));
                    v = v >> 7;
                end
                run.push_back(plain_byte(v[7:0]));
            end
            CMD_COPY_OP: begin
                flag = FLAG_BASE;
                v = off;
                for (i = 0; i < 4; i++) begin
                    flag[i] = 1'b1;
                    tail.push_back(v[7:0]);
                    v = v >> 8;
                    if (v == 0) break;
                end
                if (clen != COPY_LEN_IMPL) begin
                    l = clen;
                    for (i = 0; i < 3; i++) begin
                        flag[i + 4] = 1'b1;
                        tail.push_back(l[7:0]);
                        l = l >> 8;
                        if (l == 0) break;
                    end
                end
                run.push_back(plain_byte(flag));
                foreach (tail[j]) run.push_back(plain_byte(tail[j]));
            end
            CMD_INSERT_START: begin
                if (ins_left != 0) begin
                    run.push_back('{data: 8'h00, last: 1'b0, bad: 1'b1});
                end else begin
                    ins_left   = ilen;
                    chunk_left = '0;
                end
            end
            default: begin
                if (ins_left == 0) begin
                    run.push_back('{data: 8'h00, last: 1'b0, bad: 1'b1});
                end else begin
                    // open a new chunk with its count byte
                    if (chunk_left == 0) begin
                        cnt = (ins_left < 24'd127) ? ins_left[6:0] : CHUNK_MAX;
                        run.push_back(plain_byte({1'b0, cnt}));
                        chunk_left = cnt;
                    end
                    run.push_back(plain_byte(db));
                    chunk_left = chunk_left - 7'd1;
                    ins_left   = ins_left - 24'd1;
                end
            end
        endcase
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[j]) owed_bytes.push_back(run[j]);
    endtask

    // Drive one request from a falling edge, hold it until taken, then maybe idle.
    // val carries the size, the copy offset or the data byte; len the copy or insert length.
    task automatic send_request(input cmd_t cmd, input logic [31:0] val,
                                input logic [23:0] len);
        logic [31:0] sz;
        logic [31:0] off;
        logic [23:0] clen;
        logic [23:0] ilen;
        logic [7:0]  db;
        sz   = (cmd == CMD_SIZE_HEADER) ? val : $urandom;
        off  = (cmd == CMD_COPY_OP) ? val : $urandom;
        clen = (cmd == CMD_COPY_OP) ? len : 24'($urandom);
        ilen = (cmd == CMD_INSERT_START) ? len : 24'($urandom);
        db   = (cmd == CMD_INSERT_DATA) ? val[7:0] : 8'($urandom);
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_size_value    <= sz;
        s_copy_offset   <= off;
        s_copy_length   <= clen;
        s_insert_length <= ilen;
        s_data_byte     <= db;
        do @(posedge aclk); while (!s_ready);
        encode_request(cmd, sz, off, clen, ilen, db);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < 37) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_offset();
        rand_offset = $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [23:0] rand_copy_len();
        case ($urandom_range(0, 5))
            0:       rand_copy_len = COPY_LEN_IMPL;
            1:       rand_copy_len = 24'h0;
            default: rand_copy_len = 24'(($urandom & 32'hffffff) >> $urandom_range(0, 23));
        endcase
    endfunction

    task automatic test_size_headers();
        send_request(CMD_SIZE_HEADER, 32'h0, '0);
        send_request(CMD_SIZE_HEADER, 32'h7f, '0);
        send_request(CMD_SIZE_HEADER, 32'h80, '0);
        send_request(CMD_SIZE_HEADER, 32'h3fff, '0);
        send_request(CMD_SIZE_HEADER, 32'h4000, '0);
        send_request(CMD_SIZE_HEADER, 32'hffffffff, '0);
        send_request(CMD_SIZE_HEADER, 32'h12345678, '0);
    endtask

    task automatic test_copy_ops();
        send_request(CMD_COPY_OP, 32'h0, COPY_LEN_IMPL);
        send_request(CMD_COPY_OP, 32'hff, 24'h1);
        send_request(CMD_COPY_OP, 32'h100, 24'hffff);
        send_request(CMD_COPY_OP, 32'hffffffff, 24'hffffff);
        // zero length still sends one length byte
        send_request(CMD_COPY_OP, 32'h10000, 24'h0);
        send_request(CMD_COPY_OP, 32'h00ab0000, 24'h100);
    endtask

    task automatic test_insert_rules();
        send_request(CMD_INSERT_DATA, 32'h33, '0);
        send_request(CMD_INSERT_START, '0, 24'h0);
        send_request(CMD_INSERT_START, '0, 24'h3);
        send_request(CMD_INSERT_DATA, 32'h00, '0);
        send_request(CMD_SIZE_HEADER, 32'h5, '0);
        send_request(CMD_COPY_OP, 32'h40, 24'h20);
        send_request(CMD_INSERT_START, '0, 24'h2);
        send_request(CMD_INSERT_DATA, 32'hff, '0);
        send_request(CMD_INSERT_DATA, 32'h5a, '0);
        send_request(CMD_INSERT_DATA, 32'h11, '0);
    endtask

    // Cross the chunk boundary with no idling on either side.
    task automatic test_long_insert();
        int n;
        calm = 1'b1;
        n = $urandom_range(128, 160);
        send_request(CMD_INSERT_START, '0, 24'(n));
        repeat (n) send_request(CMD_INSERT_DATA, $urandom, '0);
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        int pick;
        repeat (40) begin
            pick = $urandom_range(0, 99);
            if (ins_left != 0) begin
                if (pick < 80)      send_request(CMD_INSERT_DATA, $urandom, '0);
                else if (pick < 87) send_request(CMD_SIZE_HEADER, rand_offset(), '0);
                else if (pick < 94) send_request(CMD_COPY_OP, rand_offset(), rand_copy_len());
                else                send_request(CMD_INSERT_START, '0,
                                                 24'($urandom_range(1, 12)));
            end else begin
                if (pick < 40)      send_request(CMD_INSERT_START, '0,
                                                 24'($urandom_range(1, 12)));
                else if (pick < 65) send_request(CMD_SIZE_HEADER, rand_offset(), '0);
                else if (pick < 88) send_request(CMD_COPY_OP, rand_offset(), rand_copy_len());
                else if (pick < 95) send_request(CMD_INSERT_DATA, $urandom, '0);
                else                send_request(CMD_INSERT_START, '0, 24'h0);
            end
        end
    endtask

    // Leave an insert of the largest length pending for the rest of the run.
    task automatic test_huge_insert();
        int pick;
        while (ins_left != 0) send_request(CMD_INSERT_DATA, $urandom, '0);
        send_request(CMD_INSERT_START, '0, 24'hffffff);
        repeat (25) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      send_request(CMD_INSERT_DATA, $urandom, '0);
            else if (pick < 80) send_request(CMD_SIZE_HEADER, rand_offset(), '0);
            else if (pick < 90) send_request(CMD_COPY_OP, rand_offset(), rand_copy_len());
            else                send_request(CMD_INSERT_START, '0, 24'($urandom));
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_SIZE_HEADER;
        s_size_value    = '0;
        s_copy_offset   = '0;
        s_copy_length   = '0;
        s_insert_length = '0;
        s_data_byte     = '0;
        ins_left        = '0;
        chunk_left      = '0;
        errors          = 0;
        calm            = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_size_headers();
        test_copy_ops();
        test_insert_rules();
        test_long_insert();
        test_random_mix();
        test_huge_insert();

        s_valid <= 1'b0;
        while (owed_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side backpressure
    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_bytes.size() == 0) begin
                $error("unexpected result: out_byte %h last_of_run %b bad_item %b",
                       m_out_byte, m_last_of_run, m_bad_item);
                errors++;
            end else begin
                due = owed_bytes.pop_front();
                if (m_out_byte !== due.data) begin
                    $error("out_byte: expected %h, got %h", due.data, m_out_byte);
                    errors++;
                end
                if (m_last_of_run !== due.last) begin
                    $error("last_of_run: expected %b, got %b", due.last, m_last_of_run);
                    errors++;
                end
                if (m_bad_item !== due.bad) begin
                    $error("bad_item: expected %b, got %b", due.bad, m_bad_item);
                    errors++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
